### src/mexp_pkg.sv
// shared constants, types and microprogram for the modular exponentiation core
package mexp_pkg;

    localparam int MOD_BITS      = 16;
    localparam int EXP_BITS      = 31;
    localparam int CNT_BITS      = $clog2(MOD_BITS + 1);
    localparam int PC_BITS       = 4;
    localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(23);

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_MUL_BUSY,
        C_EXP_ZERO,
        C_EXP_EVEN,
        C_OUT_FULL
    } t_cond;

    typedef enum logic {
        A_ONE,
        A_BASE
    } t_asel;

    typedef enum logic {
        B_BASE,
        B_ACC
    } t_bsel;

    typedef enum logic [1:0] {
        D_NONE,
        D_ACC,
        D_BASE
    } t_dst;

    typedef struct packed {
        t_cond              cond;
        logic [PC_BITS-1:0] target;
        logic               in_ready;
        logic               mul_start;
        t_asel              asel;
        t_bsel              bsel;
        t_dst               wr_dst;
        logic               shift_exp;
        logic               out_load;
    } t_ctrl;

    typedef struct packed {
        logic                in_valid;
        logic                mul_busy;
        logic                exp_zero;
        logic                exp_even;
        logic                out_full;
        logic [MOD_BITS-1:0] modulus;
    } t_status;

    // step addresses
    localparam logic [PC_BITS-1:0] S_IDLE  = PC_BITS'(0);
    localparam logic [PC_BITS-1:0] S_RED_W = PC_BITS'(2);
    localparam logic [PC_BITS-1:0] S_LOOP  = PC_BITS'(4);
    localparam logic [PC_BITS-1:0] S_MUL_W = PC_BITS'(7);
    localparam logic [PC_BITS-1:0] S_SQR   = PC_BITS'(9);
    localparam logic [PC_BITS-1:0] S_SQR_W = PC_BITS'(10);
    localparam logic [PC_BITS-1:0] S_OUT   = PC_BITS'(12);

    function automatic t_ctrl ctrl_word(input t_cond c, input logic [PC_BITS-1:0] tgt);
        t_ctrl w;
        w           = '0;
        w.cond      = c;
        w.target    = tgt;
        w.asel      = A_ONE;
        w.bsel      = B_BASE;
        w.wr_dst    = D_NONE;
        return w;
    endfunction

    // microprogram rom
    function automatic t_ctrl rom_word(input logic [PC_BITS-1:0] pc);
        t_ctrl w;
        w = ctrl_word(C_NEVER, S_IDLE);
        case (pc)
            4'd0: begin    // wait for a request, load operands on accept
                w = ctrl_word(C_NO_INPUT, S_IDLE);
                w.in_ready = 1'b1;
            end
            4'd1: begin    // base mod m as 1 * base
                w.mul_start = 1'b1;
                w.asel      = A_ONE;
                w.bsel      = B_BASE;
            end
            4'd2: w = ctrl_word(C_MUL_BUSY, S_RED_W);
            4'd3: w.wr_dst = D_BASE;
            4'd4: w = ctrl_word(C_EXP_ZERO, S_OUT);
            4'd5: w = ctrl_word(C_EXP_EVEN, S_SQR);
            4'd6: begin    // acc * base
                w.mul_start = 1'b1;
                w.asel      = A_BASE;
                w.bsel      = B_ACC;
            end
            4'd7: w = ctrl_word(C_MUL_BUSY, S_MUL_W);
            4'd8: w.wr_dst = D_ACC;
            4'd9: begin    // base * base, next exponent bit
                w.mul_start = 1'b1;
                w.asel      = A_BASE;
                w.bsel      = B_BASE;
                w.shift_exp = 1'b1;
            end
            4'd10: w = ctrl_word(C_MUL_BUSY, S_SQR_W);
            4'd11: begin
                w        = ctrl_word(C_ALWAYS, S_LOOP);
                w.wr_dst = D_BASE;
            end
            4'd12: begin    // hold until the output register frees up
                w          = ctrl_word(C_OUT_FULL, S_OUT);
                w.out_load = 1'b1;
            end
            4'd13: w = ctrl_word(C_ALWAYS, S_IDLE);
            default: w = ctrl_word(C_ALWAYS, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

### src/mexp_mulmod.sv
// bit-serial modular multiplier, one multiplier bit per cycle
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOD_BITS-1:0] i_a,
    input  logic [MOD_BITS-1:0] i_b,
    input  logic [MOD_BITS-1:0] i_mod,
    output logic                o_busy,
    output logic [MOD_BITS-1:0] o_result
);

    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [MOD_BITS-1:0] r_a, r_b, r_r;
    logic [MOD_BITS-1:0] n_b, n_r;
    logic [MOD_BITS:0]   w_dbl, w_dbl_red, w_sum, w_sum_red;

    assign o_busy   = (r_cnt != '0);
    assign o_result = r_r;

    // r = 2r + bit * a, both steps kept below m
    always_comb begin
        w_dbl     = {r_r, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, i_mod}) ? w_dbl - {1'b0, i_mod} : w_dbl;
        w_sum     = w_dbl_red + (r_b[MOD_BITS-1] ? {1'b0, r_a} : '0);
        w_sum_red = (w_sum >= {1'b0, i_mod}) ? w_sum - {1'b0, i_mod} : w_sum;
    end

    always_comb begin
        n_cnt = r_cnt;
        n_b   = r_b;
        n_r   = r_r;
        if (i_start) begin
            n_cnt = CNT_BITS'(MOD_BITS);
            n_b   = i_b;
            n_r   = '0;
        end else if (o_busy) begin
            n_cnt = r_cnt - CNT_BITS'(1);
            n_b   = {r_b[MOD_BITS-2:0], 1'b0};
            n_r   = w_sum_red[MOD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
        end
        r_b <= n_b;
        r_r <= n_r;
    end

endmodule

### src/mexp_dp.sv
// datapath: modulus, operand registers, multiplier and output register
module mexp_dp
    import mexp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl               i_ctrl,
    input  logic                i_in_valid,
    input  logic [MOD_BITS-1:0] i_base_value,
    input  logic [EXP_BITS-1:0] i_exponent,
    input  logic                i_out_ready,
    input  logic                i_cfg_we,
    input  logic [MOD_BITS-1:0] i_cfg_data,
    output t_status             o_status,
    output logic                o_out_valid,
    output logic [MOD_BITS-1:0] o_power_result
);

    logic [MOD_BITS-1:0] r_mod, r_acc, r_base, r_out;
    logic [EXP_BITS-1:0] r_exp;
    logic                r_out_valid, n_out_valid;
    logic                w_accept, w_out_full, w_mul_busy;
    logic [MOD_BITS-1:0] w_a, w_b, w_prod;

    assign w_accept   = i_in_valid & i_ctrl.in_ready;
    assign w_out_full = r_out_valid & ~i_out_ready;
    assign w_a        = (i_ctrl.asel == A_BASE) ? r_base : MOD_BITS'(1);
    assign w_b        = (i_ctrl.bsel == B_ACC) ? r_acc : r_base;

    mexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_ctrl.mul_start),
        .i_a      (w_a),
        .i_b      (w_b),
        .i_mod    (r_mod),
        .o_busy   (w_mul_busy),
        .o_result (w_prod)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_ctrl.out_load && !w_out_full) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod       <= MODULUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mod <= i_cfg_data;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acc  <= MOD_BITS'(1);
            r_base <= i_base_value;
            r_exp  <= i_exponent;
        end else begin
            if (i_ctrl.wr_dst == D_ACC) begin
                r_acc <= w_prod;
            end
            if (i_ctrl.wr_dst == D_BASE) begin
                r_base <= w_prod;
            end
            if (i_ctrl.shift_exp) begin
                r_exp <= r_exp >> 1;
            end
        end
        // modulus of zero or one gives zero
        if (i_ctrl.out_load && !w_out_full) begin
            r_out <= (r_mod < MOD_BITS'(2)) ? '0 : r_acc;
        end
    end

    assign o_status.in_valid = i_in_valid;
    assign o_status.mul_busy = w_mul_busy;
    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.exp_even = ~r_exp[0];
    assign o_status.out_full = w_out_full;
    assign o_status.modulus  = r_mod;

    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_out;

endmodule

### src/mexp_seq.sv
// microcode sequencer: step counter, rom and conditional jumps
module mexp_seq
    import mexp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    logic [PC_BITS-1:0] r_pc, n_pc;
    t_ctrl              w_ctrl;
    logic               w_take;

    assign w_ctrl = rom_word(r_pc);
    assign o_ctrl = w_ctrl;

    always_comb begin
        case (w_ctrl.cond)
            C_NEVER:    w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_NO_INPUT: w_take = ~i_status.in_valid;
            C_MUL_BUSY: w_take = i_status.mul_busy;
            C_EXP_ZERO: w_take = i_status.exp_zero;
            C_EXP_EVEN: w_take = i_status.exp_even;
            C_OUT_FULL: w_take = i_status.out_full;
            default:    w_take = 1'b1;
        endcase
        n_pc = w_take ? w_ctrl.target : r_pc + PC_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

### src/modular_exponentiation_core.sv
// top level: microcoded square-and-multiply modular exponentiation core
// work: the base is first reduced with one product, then for each exponent bit up to the top set
//   bit one multiply if the bit is set and one square; a zero exponent goes straight to the output
// requests: one at a time, every modular product runs on the one serial multiplier; the next
//   request is taken once the result loads and the sequencer is back at idle, even while it waits
// reset: synchronous active-low; modulus returns to 23, sequencer to the idle step
module modular_exponentiation_core
    import mexp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MOD_BITS-1:0] i_base_value,
    input  logic [EXP_BITS-1:0] i_exponent,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [MOD_BITS-1:0] o_power_result,
    input  logic                i_cfg_we,
    input  logic [MOD_BITS-1:0] i_cfg_data
);

    // control word from the rom drives the datapath each step
    t_ctrl   w_ctrl;
    // flags fed back to the sequencer for jumps
    t_status w_status;

    // request is taken only on the idle step
    assign o_in_ready = w_ctrl.in_ready;

    mexp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    // operand registers, serial multiplier and the output register
    mexp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_in_valid     (i_in_valid),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .i_out_ready    (i_out_ready),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_power_result (o_power_result)
    );

    // a new request never lands while a product is in flight
    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_status.mul_busy)
        else $error("request accepted during multiply");

    // a fresh result comes only from the output step
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctrl.out_load))
        else $error("result appeared without output step");

    // every result under a modulus of two or more is fully reduced
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (w_status.modulus >= MOD_BITS'(2)))
            |-> (o_power_result < w_status.modulus))
        else $error("result not reduced");

endmodule

### verif/modular_exponentiation_core_tb.sv
// self-checking testbench for the modular exponentiation core
`timescale 1ns / 100ps

module modular_exponentiation_core_tb;
    import mexp_pkg::*;

    localparam int          CYCLE_LIMIT     = 2_000_000; // far above the slowest legal run
    localparam int          DRAIN_CYCLES    = 1300;      // one worst-case request, 31-bit exponent
    localparam int          PRESSURE_CYCLES = 3000;      // receiver hold-off to back up the core
    localparam int          PHASE_COUNT     = 11;
    localparam int          DIRECTED_COUNT  = 25;
    localparam logic [EXP_BITS-1:0] EXP_ALL = '1;

    // one directed request, with an optional modulus write ahead of it
    typedef struct packed {
        logic                set_mod;
        logic [MOD_BITS-1:0] modulus;
        logic [MOD_BITS-1:0] base_value;
        logic [EXP_BITS-1:0] exponent;
        logic                known;
        logic [MOD_BITS-1:0] power_result;
    } t_directed_row;

    localparam t_directed_row DIRECTED[DIRECTED_COUNT] = '{
        // modulus 23 out of reset
        '{1'b0, 16'd0,     16'd0,     31'd0,         1'b1, 16'd1},     // zero exponent
        '{1'b0, 16'd0,     16'd65535, 31'd0,         1'b1, 16'd1},
        '{1'b0, 16'd0,     16'd0,     31'd1,         1'b1, 16'd0},     // zero base
        '{1'b0, 16'd0,     16'd0,     EXP_ALL,       1'b1, 16'd0},
        '{1'b0, 16'd0,     16'd1,     EXP_ALL,       1'b1, 16'd1},
        '{1'b0, 16'd0,     16'd23,    31'd5,         1'b1, 16'd0},     // base equal to modulus
        '{1'b0, 16'd0,     16'd46,    31'd1,         1'b1, 16'd0},
        '{1'b0, 16'd0,     16'd2,     31'd1,         1'b1, 16'd2},
        '{1'b0, 16'd0,     16'd22,    EXP_ALL,       1'b1, 16'd22},    // minus one, odd power
        '{1'b0, 16'd0,     16'd5,     31'd22,        1'b1, 16'd1},     // fermat
        '{1'b0, 16'd0,     16'd65535, EXP_ALL,       1'b0, 16'd0},
        '{1'b0, 16'd0,     16'd3,     31'h40000000,  1'b0, 16'd0},
        '{1'b0, 16'd0,     16'd7,     31'h55555555,  1'b0, 16'd0},
        '{1'b0, 16'd0,     16'd12345, 31'h2AAAAAAA,  1'b0, 16'd0},
        // largest modulus
        '{1'b1, 16'd65535, 16'd65534, 31'd2,         1'b1, 16'd1},
        '{1'b0, 16'd0,     16'd65535, 31'd3,         1'b1, 16'd0},
        '{1'b0, 16'd0,     16'd65535, 31'd0,         1'b1, 16'd1},
        '{1'b0, 16'd0,     16'd40000, EXP_ALL,       1'b0, 16'd0},
        // smallest legal modulus
        '{1'b1, 16'd2,     16'd65535, EXP_ALL,       1'b1, 16'd1},
        '{1'b0, 16'd0,     16'd65534, 31'd5,         1'b1, 16'd0},
        // modulus of one: everything folds to zero, zero exponent too
        '{1'b1, 16'd1,     16'd7,     31'd0,         1'b1, 16'd0},
        '{1'b0, 16'd0,     16'd65535, EXP_ALL,       1'b1, 16'd0},
        // modulus of zero
        '{1'b1, 16'd0,     16'd7,     31'd0,         1'b1, 16'd0},
        '{1'b0, 16'd0,     16'd65535, 31'd12345,     1'b1, 16'd0},
        // large prime, minus one to an odd power
        '{1'b1, 16'd65521, 16'd65520, EXP_ALL,       1'b1, 16'd65520}
    };

    // dut inputs, all known from time zero
    logic                i_clk;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic [MOD_BITS-1:0] i_base_value   = '0;
    logic [EXP_BITS-1:0] i_exponent     = '0;
    logic                i_out_ready    = 1'b0;
    logic                i_cfg_we       = 1'b0;
    logic [MOD_BITS-1:0] i_cfg_data     = '0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [MOD_BITS-1:0] o_power_result;

    // predictor state and scoreboard
    logic [MOD_BITS-1:0] cur_modulus    = MODULUS_RESET;
    logic [MOD_BITS-1:0] expected_powers[$];
    logic [MOD_BITS-1:0] oldest_power;

    bit                  quiet_sender   = 1'b0;  // no gaps between requests
    bit                  quiet_receiver = 1'b0;  // no stalls on the result side
    bit                  pressure_req   = 1'b0;  // receiver takes a long hold-off
    int                  error_count    = 0;
    int                  requests_sent  = 0;
    int                  results_checked = 0;
    int                  settings_used  = 1;
    int                  cycle_count    = 0;

    modular_exponentiation_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_power_result (o_power_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // right-to-left square and multiply, products kept at double width
    function automatic logic [MOD_BITS-1:0] predict_power(
        input logic [MOD_BITS-1:0] base_value,
        input logic [EXP_BITS-1:0] exponent,
        input logic [MOD_BITS-1:0] modulus
    );
        logic [2*MOD_BITS-1:0] acc;
        logic [2*MOD_BITS-1:0] run;
        logic [2*MOD_BITS-1:0] m;
        logic [EXP_BITS-1:0]   rest;
        // modulus of zero or one has no meaningful residue but zero
        if (modulus < 2) return '0;
        m    = {{MOD_BITS{1'b0}}, modulus};
        run  = {{MOD_BITS{1'b0}}, base_value} % m;
        acc  = 1;
        rest = exponent;
        for (int i = 0; i < EXP_BITS; i++) begin
            if (rest[0]) acc = (acc * run) % m;
            rest = rest >> 1;
            run  = (run * run) % m;
        end
        return acc[MOD_BITS-1:0];
    endfunction

    // mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    // offer one request, hold it until accepted, then book the expected power
    task automatic send_request(
        input logic [MOD_BITS-1:0] base_value,
        input logic [EXP_BITS-1:0] exponent,
        input logic                known,
        input logic [MOD_BITS-1:0] known_result
    );
        int gap;
        gap = pick_gap(quiet_sender);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_base_value <= base_value;
        i_exponent   <= exponent;
        do @(posedge i_clk); while (!o_in_ready);
        expected_powers.push_back(known ? known_result
                                        : predict_power(base_value, exponent, cur_modulus));
        requests_sent++;
    endtask

    // modulus changes only with nothing in flight
    task automatic write_modulus(input logic [MOD_BITS-1:0] modulus);
        i_in_valid <= 1'b0;
        while (expected_powers.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= modulus;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_modulus = modulus;
        settings_used++;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
                stall_left = 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end else begin
                stall_left = pick_gap(quiet_receiver);
                i_out_ready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // compare each accepted result with the oldest booked power
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_powers.size() == 0) begin
                $error("power_result: expected none pending, actual %0d", o_power_result);
                error_count++;
            end else begin
                oldest_power = expected_powers.pop_front();
                results_checked++;
                if (o_power_result !== oldest_power) begin
                    $error("power_result: expected %0d, actual %0d",
                           oldest_power, o_power_result);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus
    initial begin
        logic [MOD_BITS-1:0] phase_mod [PHASE_COUNT];
        int                  phase_items;
        logic [MOD_BITS-1:0] base_value;
        logic [EXP_BITS-1:0] exponent;
        int                  pick;

        // hold reset low from time zero, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, first ones run on the reset modulus
        for (int row = 0; row < DIRECTED_COUNT; row++) begin
            if (DIRECTED[row].set_mod) write_modulus(DIRECTED[row].modulus);
            send_request(DIRECTED[row].base_value, DIRECTED[row].exponent,
                         DIRECTED[row].known, DIRECTED[row].power_result);
        end

        // random phases over a spread of moduli, extremes included
        phase_mod = '{16'd65521, 16'd65535, 16'd2, 16'd3, 16'd0, 16'd1,
                      16'($urandom_range(2, 65535)), 16'($urandom_range(4, 64)),
                      16'($urandom_range(2, 65535)), MODULUS_RESET, 16'd257};
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            write_modulus(phase_mod[ph]);
            phase_items    = (phase_mod[ph] < 2) ? 8 : 28;
            // one phase runs with no idling on either side
            quiet_sender   = (ph == 3);
            quiet_receiver = (ph == 3);

            if (ph == 0) begin
                // back up the core: receiver holds off while requests keep coming
                pressure_req = 1'b1;
                quiet_sender = 1'b1;
                for (int k = 0; k < 6; k++) begin
                    send_request(16'($urandom()), 31'($urandom_range(0, 15)), 1'b0, '0);
                end
                quiet_sender = 1'b0;
                phase_items  = phase_items - 6;
            end

            for (int k = 0; k < phase_items; k++) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       base_value = '0;
                    1:       base_value = cur_modulus - 1'b1;
                    2:       base_value = '1;
                    3:       base_value = cur_modulus;
                    default: base_value = 16'($urandom());
                endcase
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       exponent = 31'($urandom_range(0, 40));
                    1:       exponent = EXP_ALL;
                    2:       exponent = EXP_ALL & (31'd1 << $urandom_range(0, EXP_BITS - 1));
                    default: exponent = 31'($urandom());
                endcase
                send_request(base_value, exponent, 1'b0, '0);
            end
        end

        // wait for every booked result, then watch for stray ones
        i_in_valid     <= 1'b0;
        quiet_receiver = 1'b0;
        while (expected_powers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests over %0d modulus settings, zero and one included",
                 requests_sent, settings_used);
        $display("%0d results compared, %0d mismatches", results_checked, error_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
